// ===== hdl/seteu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seteu_pkg
// Shared types, size codes and offset tables for the sprite entry tile
// expander.
// ----------------------------------------------------------------------------
package seteu_pkg;

    // size codes from attribute bits 3..1
    localparam logic [2:0] SIZE_2X2 = 3'd0;
    localparam logic [2:0] SIZE_2X1 = 3'd1;
    localparam logic [2:0] SIZE_1X2 = 3'd2;
    localparam logic [2:0] SIZE_1X1 = 3'd3;
    localparam logic [2:0] SIZE_4X4 = 3'd4;

    // classified sprite entry, ready to be walked tile by tile
    typedef struct packed {
        logic [13:0] base;     // masked base tile code
        logic [3:0]  color;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  start_x;  // signed x before the column and +16 offsets
        logic [7:0]  start_y;
        logic [1:0]  cols_m1;  // width in tiles minus one
        logic [1:0]  rows_m1;  // height in tiles minus one
    } desc_t;

    // queue status seen by the front and the top
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // sequencer position seen by the top
    typedef struct packed {
        logic       busy;
        logic [1:0] col;
        logic [1:0] row;
        logic [1:0] cols_m1;
        logic [1:0] rows_m1;
    } back_stat_t;

    // column offset within a row of tiles
    function automatic logic [3:0] col_off(input logic [1:0] idx);
        logic [3:0] v;
        case (idx)
            2'd0:    v = 4'h0;
            2'd1:    v = 4'h1;
            2'd2:    v = 4'h4;
            2'd3:    v = 4'h5;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

    // row offset down the sprite
    function automatic logic [3:0] row_off(input logic [1:0] idx);
        logic [3:0] v;
        case (idx)
            2'd0:    v = 4'h0;
            2'd1:    v = 4'h2;
            2'd2:    v = 4'h8;
            2'd3:    v = 4'ha;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/seteu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seteu_front
// Accepts sprite list entries and decodes them into tile walk descriptors:
// base code, size, flips and start position.
// ----------------------------------------------------------------------------
module seteu_front (
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [39:0]       s_tdata,
    input  wire seteu_pkg::queue_stat_t q_stat,
    output logic                   push_valid,
    output seteu_pkg::desc_t       push_desc
);
    import seteu_pkg::*;

    logic [7:0]  code;
    logic [7:0]  bank_color;
    logic [7:0]  ypos;
    logic [7:0]  xpos;
    logic [7:0]  attr;
    logic [13:0] base_raw;

    // unpack the entry
    assign code       = s_tdata[7:0];
    assign bank_color = s_tdata[15:8];
    assign ypos       = s_tdata[23:16];
    assign xpos       = s_tdata[31:24];
    assign attr       = s_tdata[39:32];

    // handshake straight into the queue
    assign s_tready   = !q_stat.full;
    assign push_valid = s_tvalid && !q_stat.full;

    // base code: bank bits above the sprite number, fine bits at the bottom
    assign base_raw = {attr[7:6], bank_color[1:0], code, bank_color[3:2]};

    // size and code mask
    always_comb begin
        push_desc.color   = bank_color[7:4];
        push_desc.flip_x  = attr[4];
        push_desc.flip_y  = attr[5];
        push_desc.start_x = {attr[0], attr[0], xpos};
        push_desc.start_y = ypos;
        push_desc.base    = base_raw;
        push_desc.cols_m1 = 2'd0;
        push_desc.rows_m1 = 2'd0;
        case (attr[3:1])
            SIZE_2X2: begin
                push_desc.cols_m1 = 2'd1;
                push_desc.rows_m1 = 2'd1;
                push_desc.base    = {base_raw[13:2], 2'b00};
            end
            SIZE_2X1: begin
                push_desc.cols_m1 = 2'd1;
                push_desc.base    = {base_raw[13:1], 1'b0};
            end
            SIZE_1X2: begin
                push_desc.rows_m1 = 2'd1;
                push_desc.base    = {base_raw[13:2], 1'b0, base_raw[0]};
            end
            SIZE_4X4: begin
                push_desc.cols_m1 = 2'd3;
                push_desc.rows_m1 = 2'd3;
                push_desc.base    = {base_raw[13:2], 2'b00};
            end
            // single tile, also for unknown codes
            default: begin
                push_desc.cols_m1 = 2'd0;
                push_desc.rows_m1 = 2'd0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/seteu_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seteu_queue
// Short descriptor queue between the decode front and the tile sequencer.
// ----------------------------------------------------------------------------
module seteu_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    input  wire seteu_pkg::desc_t  push_desc,
    input  wire logic              pop,
    output seteu_pkg::desc_t       pop_desc,
    output seteu_pkg::queue_stat_t q_stat
);
    import seteu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    desc_t           entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push_valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_desc     = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/seteu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// seteu_back
// Tile sequencer: walks each descriptor row by row, left to right, emitting
// one tile per cycle through a registered output stage when not stalled.
// ----------------------------------------------------------------------------
module seteu_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire seteu_pkg::queue_stat_t q_stat,
    input  wire seteu_pkg::desc_t  pop_desc,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,
    output logic                   m_tlast,
    output seteu_pkg::back_stat_t  b_stat
);
    import seteu_pkg::*;

    desc_t       cur_reg;
    logic        busy_reg, busy_next;
    logic [1:0]  col_reg, col_next;
    logic [1:0]  row_reg, row_next;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg;
    logic        out_last_reg;
    logic        advance;
    logic        tile_last;
    logic        load;
    logic [1:0]  eff_col;
    logic [1:0]  eff_row;
    logic [14:0] tile_code;
    logic [9:0]  screen_x;
    logic [8:0]  screen_y;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign b_stat.busy    = busy_reg;
    assign b_stat.col     = col_reg;
    assign b_stat.row     = row_reg;
    assign b_stat.cols_m1 = cur_reg.cols_m1;
    assign b_stat.rows_m1 = cur_reg.rows_m1;

    // issue a tile when the output stage is free or being drained
    assign advance   = busy_reg && (!out_valid_reg || m_tready);
    assign tile_last = (col_reg == cur_reg.cols_m1) && (row_reg == cur_reg.rows_m1);
    assign load      = (!busy_reg || (advance && tile_last)) && !q_stat.empty;
    assign pop       = load;

    // flipped table indexes
    assign eff_col = cur_reg.flip_x ? (cur_reg.cols_m1 - col_reg) : col_reg;
    assign eff_row = cur_reg.flip_y ? (cur_reg.rows_m1 - row_reg) : row_reg;

    // tile code and screen position
    assign tile_code = {1'b0, cur_reg.base} + {11'd0, col_off(eff_col)}
                     + {11'd0, row_off(eff_row)};
    assign screen_x  = cur_reg.start_x + {5'd0, col_reg, 3'b000} + 10'd16;
    assign screen_y  = {1'b0, cur_reg.start_y} + {4'd0, row_reg, 3'b000};

    // walk position
    always_comb begin
        busy_next      = busy_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
            if (col_reg == cur_reg.cols_m1) begin
                col_next = 2'd0;
                row_next = row_reg + 2'd1;
            end else begin
                col_next = col_reg + 2'd1;
            end
            if (tile_last) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            col_next  = 2'd0;
            row_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            col_reg       <= 2'd0;
            row_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // descriptor and output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= pop_desc;
        end
        if (advance) begin
            out_data_reg <= {screen_y, screen_x, cur_reg.flip_y, cur_reg.flip_x,
                             cur_reg.color, tile_code};
            out_last_reg <= tile_last;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sprite_entry_tile_expander_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander_unit
// Expands five-byte sprite list entries into 8x8 tile draw commands.
// ----------------------------------------------------------------------------
// Each accepted item is one sprite entry and yields 1, 2, 4 or 16 tile
// commands (1x1, 2x1 or 1x2, 2x2, 4x4; unknown size codes give one tile),
// emitted row by row, left to right, with m_tlast on the final tile. The
// tile sequencer emits one command per cycle unless m_tready stalls it, and
// an entry's tiles follow straight on from the previous entry's. Entries are
// decoded on acceptance and wait in a QUEUE_DEPTH-entry queue, so s_tready
// stays high while the queue has room, even while the output is stalled.
// With the sequencer idle, an entry moves from the queue into the descriptor
// and then the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sprite_entry_tile_expander_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input entries
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // sprite_code, bank_color, y_position,
                                        // x_position, attributes (8 bits each)
    // tile commands
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // tile_code[14:0], palette_color[18:15],
                                        // flip_x[19], flip_y[20], screen_x[30:21],
                                        // screen_y[39:31]
    output logic             m_tlast    // last_tile
);
    import seteu_pkg::*;

    queue_stat_t q_stat;
    back_stat_t  b_stat;
    desc_t       push_desc;
    desc_t       pop_desc;
    logic        push_valid;
    logic        pop;

    // decode front
    seteu_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_stat     (q_stat),
        .push_valid (push_valid),
        .push_desc  (push_desc)
    );

    // descriptor queue
    seteu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_desc  (push_desc),
        .pop        (pop),
        .pop_desc   (pop_desc),
        .q_stat     (q_stat)
    );

    // tile sequencer
    seteu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_desc (pop_desc),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .b_stat   (b_stat)
    );

    // walk position stays inside the sprite
    a_walk_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        b_stat.busy |-> (b_stat.col <= b_stat.cols_m1) && (b_stat.row <= b_stat.rows_m1))
        else $error("tile walk position outside sprite");

    // a full queue never takes an entry
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !s_tready)
        else $error("entry accepted while queue full");

    // sequencer picks up waiting work whenever it is idle
    a_no_idle_with_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (!b_stat.busy && !q_stat.empty) |=> b_stat.busy)
        else $error("sequencer idle with queued entry");

    // a busy sequencer issues a tile whenever its output stage is empty
    a_issue_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_stat.busy && !m_tvalid) |=> m_tvalid)
        else $error("busy sequencer failed to issue a tile");

endmodule
`default_nettype wire

// ===== bench/tb_sprite_entry_tile_expander_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sprite_entry_tile_expander_unit
// Sends sprite list entries into the tile expander and checks every tile
// command against a local expansion of the entry: size decode, code masking,
// flipped offset order, screen positions and the last-tile flag. Both sides
// of the stream idle in random bursts, except in the closing back-to-back run.
// ----------------------------------------------------------------------------
module tb_sprite_entry_tile_expander_unit;

    import seteu_pkg::*;

    // one tile command as it leaves the block
    typedef struct packed {
        logic [14:0] tile_code;
        logic [3:0]  palette_color;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  screen_x;
        logic [8:0]  screen_y;
        logic        last_tile;
    } tile_cmd_t;

    // offset tables, four bits per entry, entry 0 in the low nibble
    localparam logic [15:0] COL_STEP = 16'h5410;
    localparam logic [15:0] ROW_STEP = 16'ha820;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    tile_cmd_t   pending_tiles[$];
    int          tile_errors = 0;
    bit          idle_on = 1'b1;

    sprite_entry_tile_expander_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #800000;
        $display("status: fail");
        $finish;
    end

    // pack the five entry bytes, byte 0 lowest
    function automatic logic [39:0] pack_entry(input logic [7:0] code, input logic [7:0] bc,
                                               input logic [7:0] ypos, input logic [7:0] xpos,
                                               input logic [7:0] attr);
        return {attr, xpos, ypos, bc, code};
    endfunction

    // expand one entry into the tile commands it should produce
    task automatic expand_entry(input logic [39:0] entry);
        logic [7:0]  code, bc, ypos, xpos, attr;
        logic [13:0] base;
        int          cols, rows, x, y, ex, ey, px, py;
        tile_cmd_t   cmd;
        code = entry[7:0];
        bc   = entry[15:8];
        ypos = entry[23:16];
        xpos = entry[31:24];
        attr = entry[39:32];
        // sprite number with both bank fields above it and the fine bits below
        base = {attr[7:6], bc[1:0], code, bc[3:2]};
        cols = 1;
        rows = 1;
        case (attr[3:1])
            SIZE_2X2: begin
                cols = 2;
                rows = 2;
                base[1:0] = 2'b00;
            end
            SIZE_2X1: begin
                cols = 2;
                base[0] = 1'b0;
            end
            SIZE_1X2: begin
                rows = 2;
                base[1] = 1'b0;
            end
            SIZE_4X4: begin
                cols = 4;
                rows = 4;
                base[1:0] = 2'b00;
            end
            default: ;  // single tile, code untouched
        endcase
        // positions advance normally, flips only reverse the table reads
        for (y = 0; y < rows; y++) begin
            for (x = 0; x < cols; x++) begin
                ex = attr[4] ? cols - 1 - x : x;
                ey = attr[5] ? rows - 1 - y : y;
                px = int'(xpos) - (attr[0] ? 256 : 0) + x * 8 + 16;
                py = int'(ypos) + y * 8;
                cmd.tile_code     = 15'(base) + COL_STEP[ex*4 +: 4] + ROW_STEP[ey*4 +: 4];
                cmd.palette_color = bc[7:4];
                cmd.flip_x        = attr[4];
                cmd.flip_y        = attr[5];
                cmd.screen_x      = px[9:0];
                cmd.screen_y      = py[8:0];
                cmd.last_tile     = (x == cols - 1) && (y == rows - 1);
                pending_tiles.push_back(cmd);
            end
        end
    endtask

    // offer one entry, optionally after an idle burst, until it is taken
    task automatic send_entry(input logic [39:0] entry);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= entry;
        do @(posedge aclk); while (!s_tready);
        expand_entry(entry);
    endtask

    // any 40-bit entry, with the largest size drawn more often
    function automatic logic [39:0] random_entry();
        logic [39:0] e;
        e = 40'({$urandom, $urandom});
        if ($urandom_range(0, 2) == 0)
            e[35:33] = SIZE_4X4;
        return e;
    endfunction

    // every size code, known and unknown
    task automatic test_size_codes();
        int s;
        for (s = 0; s < 8; s++)
            send_entry(pack_entry(8'h5a, 8'h3d, 8'h40, 8'h80, {2'b01, 2'b00, 3'(s), 1'b0}));
    endtask

    // all flip combinations on the largest sprite, one flip on each strip
    task automatic test_flips();
        int f;
        for (f = 0; f < 4; f++)
            send_entry(pack_entry(8'hc3, 8'h96, 8'h10, 8'h20, {2'b10, 2'(f), SIZE_4X4, 1'b0}));
        send_entry(pack_entry(8'h27, 8'h4e, 8'h08, 8'h30, {2'b00, 2'b01, SIZE_2X1, 1'b0}));
        send_entry(pack_entry(8'h27, 8'h4e, 8'h08, 8'h30, {2'b00, 2'b10, SIZE_1X2, 1'b0}));
    endtask

    // field extremes and both ends of the screen
    task automatic test_extremes();
        send_entry(pack_entry(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_entry(pack_entry(8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
        // far left: x high bit with x low byte zero
        send_entry(pack_entry(8'h80, 8'hf0, 8'h00, 8'h00, {2'b11, 2'b00, SIZE_4X4, 1'b1}));
        // far right and bottom, top code with all bank and fine bits
        send_entry(pack_entry(8'hff, 8'hff, 8'hff, 8'hff, {2'b11, 2'b11, SIZE_4X4, 1'b0}));
        send_entry(pack_entry(8'hff, 8'h0f, 8'h00, 8'h7f, {2'b11, 2'b00, SIZE_1X1, 1'b1}));
        send_entry(pack_entry(8'h01, 8'h0c, 8'hf8, 8'hf0, {2'b00, 2'b00, SIZE_2X1, 1'b0}));
    endtask

    task automatic test_random_entries(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_entry(random_entry());
    endtask

    // closing run with both sides always ready
    task automatic test_back_to_back(input int count);
        int i;
        idle_on = 1'b0;
        for (i = 0; i < count; i++)
            send_entry(random_entry());
    endtask

    // result side: random stall bursts while idling is on
    initial begin : result_stall
        int n;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
    end

    // compare each accepted tile command with the oldest pending one
    always @(posedge aclk) begin : check_tile
        tile_cmd_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.tile_code     = m_tdata[14:0];
            got.palette_color = m_tdata[18:15];
            got.flip_x        = m_tdata[19];
            got.flip_y        = m_tdata[20];
            got.screen_x      = m_tdata[30:21];
            got.screen_y      = m_tdata[39:31];
            got.last_tile     = m_tlast;
            if (pending_tiles.size() == 0) begin
                tile_errors++;
                if (tile_errors <= 10)
                    $display("unexpected tile command: tdata %h tlast %b", m_tdata, m_tlast);
            end else begin
                want = pending_tiles.pop_front();
                if (got !== want) begin
                    tile_errors++;
                    if (tile_errors <= 10) begin
                        $display("tile mismatch: expected code %h color %h fx %b fy %b x %0d y %0d last %b",
                                 want.tile_code, want.palette_color, want.flip_x, want.flip_y,
                                 $signed(want.screen_x), want.screen_y, want.last_tile);
                        $display("               actual   code %h color %h fx %b fy %b x %0d y %0d last %b",
                                 got.tile_code, got.palette_color, got.flip_x, got.flip_y,
                                 $signed(got.screen_x), got.screen_y, got.last_tile);
                    end
                end
            end
        end
    end

    // test sequence
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_size_codes();
        test_flips();
        test_extremes();
        test_random_entries(85);
        test_back_to_back(25);
        s_tvalid <= 1'b0;
        // drain, then keep watching for anything stray
        while (pending_tiles.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (tile_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
